// ===== design/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, reset masks the check
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the following cycle, reset masks the check
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/vrrp_pkg.sv =====
// types, codes and timer helpers for the vrrp router block
`default_nettype none
package vrrp_pkg;

	localparam int unsigned TickW     = 8;   // 256 ticks per second
	localparam int unsigned AdvTimerW = 16;
	localparam int unsigned DownTimerW = 18;

	localparam logic [7:0] PrioOwner = 8'd255;
	localparam logic [7:0] PrioLeave = 8'd0;

	typedef enum logic [1:0] {
		MODE_INIT   = 2'd0,
		MODE_BACKUP = 2'd1,
		MODE_MASTER = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_STOP  = 2'd2,
		CMD_ADV   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ERR_OK        = 3'd0,
		ERR_NOT_RUN   = 3'd1,
		ERR_OWNER_ADV = 3'd2,
		ERR_BAD_AUTH  = 3'd3,
		ERR_BAD_ADDR  = 3'd4,
		ERR_BAD_INTV  = 3'd5
	} err_t;

	localparam logic [2:0] REG_LOCAL_PRIORITY = 3'd0;
	localparam logic [2:0] REG_ADVER_INTERVAL = 3'd1;
	localparam logic [2:0] REG_PREEMPT_ENABLE = 3'd2;
	localparam logic [2:0] REG_ADDRESS_OWNER  = 3'd3;
	localparam logic [2:0] REG_LOCAL_ADDRESS  = 3'd4;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] adv_source;
		logic [7:0]  adv_priority;
		logic [7:0]  adv_interval;
		logic [7:0]  adv_auth_type;
		logic        adv_ips_match;
	} vrrp_in_t;

	typedef struct packed {
		mode_t       router_state;
		logic        send_advert;
		logic [7:0]  advert_priority;
		logic        send_garp;
		logic        add_vmac;
		logic        remove_vmac;
		err_t        error_code;
		logic [31:0] master_address;
	} vrrp_out_t;

	typedef struct packed {
		logic [7:0]  local_priority;
		logic [7:0]  adver_interval;
		logic        preempt_enable;
		logic        address_owner;
		logic [31:0] local_address;
	} vrrp_cfg_t;

	typedef struct packed {
		mode_t                  mode;
		logic [AdvTimerW-1:0]   advert_timer;
		logic [DownTimerW-1:0]  master_down_timer;
		logic [31:0]            last_advertiser;
	} vrrp_state_t;

	function automatic logic [7:0] eff_priority(input vrrp_cfg_t cfg);
		return cfg.address_owner ? PrioOwner : cfg.local_priority;
	endfunction

	function automatic logic [7:0] interval_secs(input vrrp_cfg_t cfg);
		return (cfg.adver_interval == 8'd0) ? 8'd1 : cfg.adver_interval;
	endfunction

	// interval times 256
	function automatic logic [AdvTimerW-1:0] adv_ticks(input vrrp_cfg_t cfg);
		return {interval_secs(cfg), {TickW{1'b0}}};
	endfunction

	function automatic logic [TickW:0] skew_ticks(input vrrp_cfg_t cfg);
		return 9'd256 - {1'b0, eff_priority(cfg)};
	endfunction

	// 3 * interval * 256 + skew, as two shifted adds
	function automatic logic [DownTimerW-1:0] down_ticks(input vrrp_cfg_t cfg);
		logic [7:0] iv;
		iv = interval_secs(cfg);
		return {1'b0, iv, 9'd0} + {2'b0, iv, 8'd0} + {9'd0, skew_ticks(cfg)};
	endfunction

endpackage
`default_nettype wire

// ===== design/vrrp_router_state_machine.sv =====
// top level of the vrrp virtual router state machine
//
// VRRP version 2 virtual router: modes initialize, backup and master, driven
// by event beats (tick of 1/256 s, start, stop, received advertisement).
// Every accepted event beat yields exactly one result beat carrying the mode
// after the event, the advertisement, gratuitous ARP and virtual MAC requests,
// an error code and the current master address. An event beat is taken in
// every cycle when the result side keeps up; an event passes through the event
// input register and then the result register, with the state update and all
// checks done in the single combinational pass between them.
// The result register lets the next event enter while a result waits.
// Configuration registers are written through cfg_we / cfg_index / cfg_wdata
// while no event is in flight; a write that alters skew or master-down timing
// while running restarts the running timer at full length.
`default_nettype none
module vrrp_router_state_machine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// event channel
	input  wire logic                evt_valid,
	output logic                     evt_ready,
	input  wire vrrp_pkg::vrrp_in_t  evt,
	// result channel
	output logic                     res_valid,
	input  wire logic                res_ready,
	output vrrp_pkg::vrrp_out_t      res,
	// configuration write port
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_wdata
);
	import vrrp_pkg::*;

	// configuration and protocol state
	vrrp_cfg_t   cfg_q, cfg_nxt;
	vrrp_state_t state_q, state_nxt, state_cfg;

	// event input register
	vrrp_in_t    evt_s1;
	logic        evt_valid_s1;

	// result register
	vrrp_out_t   res_q, res_nxt;
	logic        res_valid_q;

	logic        advance;
	logic        timing_change;

	// the stage moves on when the result slot is free or being emptied
	assign advance   = !res_valid_q || res_ready;
	assign evt_ready = !evt_valid_s1 || advance;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	vrrp_step u_step (
		.cfg (cfg_q),
		.cur (state_q),
		.evt (evt_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// register write decode; a priority of 0 or 255 keeps the old value
	always_comb begin
		cfg_nxt = cfg_q;
		case (cfg_index)
			REG_LOCAL_PRIORITY: begin
				if (cfg_wdata[7:0] != PrioLeave && cfg_wdata[7:0] != PrioOwner)
					cfg_nxt.local_priority = cfg_wdata[7:0];
			end
			REG_ADVER_INTERVAL: cfg_nxt.adver_interval = cfg_wdata[7:0];
			REG_PREEMPT_ENABLE: cfg_nxt.preempt_enable = cfg_wdata[0];
			REG_ADDRESS_OWNER:  cfg_nxt.address_owner  = cfg_wdata[0];
			REG_LOCAL_ADDRESS:  cfg_nxt.local_address  = cfg_wdata;
			default:            cfg_nxt = cfg_q;
		endcase
	end

	// timing change restarts the timer of the current mode with new values
	assign timing_change = (skew_ticks(cfg_nxt) != skew_ticks(cfg_q))
		|| (down_ticks(cfg_nxt) != down_ticks(cfg_q));

	always_comb begin
		state_cfg = state_q;
		if (timing_change && state_q.mode != MODE_INIT) begin
			state_cfg.advert_timer      = '0;
			state_cfg.master_down_timer = '0;
			if (state_q.mode == MODE_MASTER)
				state_cfg.advert_timer = adv_ticks(cfg_nxt);
			else if (state_q.mode == MODE_BACKUP)
				state_cfg.master_down_timer = down_ticks(cfg_nxt);
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (evt_ready) begin
			evt_valid_s1 <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_valid && evt_ready)
			evt_s1 <= evt;
	end

	// state, configuration and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_priority <= 8'd100;
			cfg_q.adver_interval <= 8'd1;
			cfg_q.preempt_enable <= 1'b1;
			cfg_q.address_owner  <= 1'b0;
			cfg_q.local_address  <= '0;
			state_q.mode              <= MODE_INIT;
			state_q.advert_timer      <= '0;
			state_q.master_down_timer <= '0;
			state_q.last_advertiser   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (evt_valid_s1 && advance) begin
				state_q     <= state_nxt;
				res_valid_q <= 1'b1;
			end else begin
				if (res_ready)
					res_valid_q <= 1'b0;
				// writes must arrive only while no event is in flight; the block does not enforce it
				if (cfg_we) begin
					cfg_q   <= cfg_nxt;
					state_q <= state_cfg;
				end
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (evt_valid_s1 && advance)
			res_q <= res_nxt;
	end

endmodule
`default_nettype wire

// ===== design/vrrp_step.sv =====
// next state and result of one event, purely combinational
`default_nettype none
module vrrp_step (
	input  wire vrrp_pkg::vrrp_cfg_t   cfg,
	input  wire vrrp_pkg::vrrp_state_t cur,
	input  wire vrrp_pkg::vrrp_in_t    evt,
	output vrrp_pkg::vrrp_state_t      nxt,
	output vrrp_pkg::vrrp_out_t        res
);
	import vrrp_pkg::*;

	logic [7:0]            me;
	logic [AdvTimerW-1:0]  adv_full;
	logic [DownTimerW-1:0] down_full;
	logic                  is_owner;
	logic                  adv_expire, down_expire;
	logic                  start_master, stop_master;
	logic                  rx_ok, rx_leave, master_leave_rx, preempted;
	err_t                  rx_err;

	assign me        = eff_priority(cfg);
	assign adv_full  = adv_ticks(cfg);
	assign down_full = down_ticks(cfg);
	assign is_owner  = (me == PrioOwner);
	assign rx_leave  = (evt.adv_priority == PrioLeave);

	assign adv_expire  = (evt.command == CMD_TICK) && (cur.mode == MODE_MASTER)
		&& (cur.advert_timer == AdvTimerW'(1));
	assign down_expire = (evt.command == CMD_TICK) && (cur.mode == MODE_BACKUP)
		&& (cur.master_down_timer == DownTimerW'(1));
	assign start_master = (evt.command == CMD_START) && (cur.mode == MODE_INIT) && is_owner;
	assign stop_master  = (evt.command == CMD_STOP) && (cur.mode == MODE_MASTER);

	// advertisement checks in code order
	always_comb begin
		if (cur.mode == MODE_INIT)
			rx_err = ERR_NOT_RUN;
		else if (is_owner)
			rx_err = ERR_OWNER_ADV;
		else if (evt.adv_auth_type != 8'd0)
			rx_err = ERR_BAD_AUTH;
		else if (!evt.adv_ips_match && evt.adv_priority != PrioOwner)
			rx_err = ERR_BAD_ADDR;
		else if (evt.adv_interval != cfg.adver_interval)
			rx_err = ERR_BAD_INTV;
		else
			rx_err = ERR_OK;
	end

	assign rx_ok           = (evt.command == CMD_ADV) && (rx_err == ERR_OK);
	assign master_leave_rx = rx_ok && (cur.mode == MODE_MASTER) && rx_leave;
	assign preempted       = rx_ok && (cur.mode == MODE_MASTER) && !rx_leave
		&& ((evt.adv_priority > me)
		|| (evt.adv_priority == me && evt.adv_source > cfg.local_address));

	// next state
	always_comb begin
		nxt = cur;
		case (evt.command)
			CMD_TICK: begin
				if (cur.mode == MODE_MASTER && cur.advert_timer != '0) begin
					nxt.advert_timer = cur.advert_timer - AdvTimerW'(1);
					if (adv_expire) begin
						nxt.advert_timer      = adv_full;
						nxt.master_down_timer = '0;
					end
				end else if (cur.mode == MODE_BACKUP && cur.master_down_timer != '0) begin
					nxt.master_down_timer = cur.master_down_timer - DownTimerW'(1);
					if (down_expire) begin
						nxt.mode              = MODE_MASTER;
						nxt.advert_timer      = adv_full;
						nxt.master_down_timer = '0;
					end
				end
			end
			CMD_START: begin
				if (cur.mode == MODE_INIT) begin
					if (is_owner) begin
						nxt.mode              = MODE_MASTER;
						nxt.advert_timer      = adv_full;
						nxt.master_down_timer = '0;
					end else begin
						nxt.mode              = MODE_BACKUP;
						nxt.advert_timer      = '0;
						nxt.master_down_timer = down_full;
					end
				end
			end
			CMD_STOP: begin
				if (cur.mode != MODE_INIT) begin
					nxt.mode              = MODE_INIT;
					nxt.advert_timer      = '0;
					nxt.master_down_timer = '0;
				end
			end
			CMD_ADV: begin
				if (rx_ok && cur.mode == MODE_BACKUP) begin
					nxt.last_advertiser = evt.adv_source;
					if (rx_leave) begin
						nxt.advert_timer      = '0;
						nxt.master_down_timer = DownTimerW'(skew_ticks(cfg));
					end else if (!cfg.preempt_enable || evt.adv_priority >= me) begin
						nxt.advert_timer      = '0;
						nxt.master_down_timer = down_full;
					end
				end else if (master_leave_rx) begin
					nxt.advert_timer      = adv_full;
					nxt.master_down_timer = '0;
				end else if (preempted) begin
					nxt.mode              = MODE_BACKUP;
					nxt.advert_timer      = '0;
					nxt.master_down_timer = down_full;
				end
			end
			default: nxt = cur;
		endcase
	end

	// result fields
	always_comb begin
		res.router_state = nxt.mode;
		res.send_advert  = adv_expire || down_expire || start_master || stop_master
			|| master_leave_rx;
		res.advert_priority = (res.send_advert && !stop_master) ? me : PrioLeave;
		res.send_garp    = down_expire || start_master;
		res.add_vmac     = down_expire || start_master;
		res.remove_vmac  = stop_master || preempted;
		res.error_code   = (evt.command == CMD_ADV) ? rx_err : ERR_OK;
		res.master_address = (nxt.mode == MODE_MASTER) ? cfg.local_address
			: nxt.last_advertiser;
	end

endmodule
`default_nettype wire

// ===== design/vrrp_checker.sv =====
// port level checks on the result channel, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module vrrp_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire vrrp_pkg::vrrp_out_t res
);
	import vrrp_pkg::*;

	`ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result beat dropped or changed while stalled")
	`ASSERT_SAME(a_prio_idle, res_valid && !res.send_advert, res.advert_priority == PrioLeave, "advert priority set without an advertisement")
	`ASSERT_SAME(a_vmac_add, res_valid && res.add_vmac, res.router_state == MODE_MASTER && res.send_garp && res.send_advert, "virtual mac added outside a move to master")
	`ASSERT_SAME(a_vmac_remove, res_valid && res.remove_vmac, res.router_state != MODE_MASTER && !res.add_vmac, "virtual mac removed while staying master")
	`ASSERT_SAME(a_err_quiet, res_valid && res.error_code != ERR_OK, !res.send_advert && !res.add_vmac && !res.remove_vmac && !res.send_garp, "rejected advertisement caused an action")

endmodule

bind vrrp_router_state_machine vrrp_checker u_vrrp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);
`default_nettype wire

// ===== tb/sv/vrrp_router_state_machine_tb.sv =====
// testbench for the vrrp router state machine: directed table, random phases, scoreboard
`timescale 1ns / 1ps
module vrrp_router_state_machine_tb;
	import vrrp_pkg::*;

	// timing of the bench
	localparam int unsigned MaxIdle       = 6;   // longest gap or stall per beat
	localparam int unsigned SettleCycles  = 6;   // pipeline depth plus margin
	localparam int unsigned NumPhases     = 7;
	localparam int unsigned PhaseBeats    = 130;
	localparam int unsigned ExpiryReach   = 300; // longest tick run aimed at a timer expiry
	// timer arithmetic of the router
	localparam int unsigned TicksPerSec   = 256;
	localparam int unsigned DownIntervals = 3;
	// register indexes past the last real one are spare and must be ignored
	localparam logic [2:0]  REG_SPARE_FIRST = 3'd5;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        evt_valid = 1'b0;
	logic        evt_ready;
	vrrp_in_t    evt = '0;
	logic        res_valid;
	logic        res_ready = 1'b1;
	vrrp_out_t   res;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_wdata = '0;

	vrrp_router_state_machine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// the bench's own copy of the configuration, at reset values
	logic [7:0]  c_prio = 8'd100;
	logic [7:0]  c_intv = 8'd1;
	logic        c_preempt = 1'b1;
	logic        c_owner = 1'b0;
	logic [31:0] c_addr = '0;

	// the bench's own copy of the router state
	mode_t                 m_mode = MODE_INIT;
	logic [AdvTimerW-1:0]  m_adv_tmr = '0;
	logic [DownTimerW-1:0] m_down_tmr = '0;
	logic [31:0]           m_last_adv = '0;

	// router outputs still owed by the block, oldest first
	vrrp_out_t router_outputs_due[$];

	int unsigned fails = 0;
	bit          gaps_on = 1'b1;    // sender idles between beats
	bit          stalls_on = 1'b1;  // receiver stalls after beats
	int unsigned hold = 0;          // receiver stall cycles still to run
	int unsigned tick_run = 0;      // ticks still owed by the current tick run

	// one row of the directed table: either a register write or an event beat
	typedef struct {
		bit          is_write;
		logic [2:0]  reg_idx;
		logic [31:0] reg_data;
		vrrp_in_t    ev;
		bit          typed;     // want holds a hand-written result
		vrrp_out_t   want;
	} plan_row_t;

	plan_row_t plan[$];

	// ---------------------------------------------------------------
	// prediction
	// ---------------------------------------------------------------

	// owner of the addresses always claims the top priority
	function automatic logic [7:0] own_priority();
		return c_owner ? PrioOwner : c_prio;
	endfunction

	// three intervals plus the skew, a zero interval counting as one second
	function automatic logic [DownTimerW-1:0] down_len();
		int unsigned secs;
		secs = (c_intv == '0) ? 1 : int'(c_intv);
		return DownTimerW'(DownIntervals * secs * TicksPerSec + TicksPerSec
			- int'(own_priority()));
	endfunction

	// only the timer of the current mode runs, at full length
	function automatic void reload_timers();
		int unsigned secs;
		secs = (c_intv == '0) ? 1 : int'(c_intv);
		m_adv_tmr = '0;
		m_down_tmr = '0;
		if (m_mode == MODE_MASTER)
			m_adv_tmr = AdvTimerW'(secs * TicksPerSec);
		else if (m_mode == MODE_BACKUP)
			m_down_tmr = down_len();
	endfunction

	// register write; a change of skew or master-down while running restarts the timer
	function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
		logic [7:0]            old_me;
		logic [DownTimerW-1:0] old_down;
		old_me = own_priority();
		old_down = down_len();
		case (idx)
			REG_LOCAL_PRIORITY: begin
				if (data[7:0] != PrioLeave && data[7:0] != PrioOwner)
					c_prio = data[7:0];
			end
			REG_ADVER_INTERVAL: c_intv = data[7:0];
			REG_PREEMPT_ENABLE: c_preempt = data[0];
			REG_ADDRESS_OWNER:  c_owner = data[0];
			REG_LOCAL_ADDRESS:  c_addr = data;
			default: return;
		endcase
		if ((old_me != own_priority() || old_down != down_len()) && m_mode != MODE_INIT)
			reload_timers();
	endfunction

	// one event beat through the router, giving the result beat it should cause
	function automatic void advance_router(input vrrp_in_t e, output vrrp_out_t r);
		logic [7:0] me;
		me = own_priority();
		r = '0;
		case (e.command)
			CMD_TICK: begin
				if (m_mode == MODE_MASTER && m_adv_tmr != '0) begin
					m_adv_tmr = m_adv_tmr - 1'b1;
					if (m_adv_tmr == '0) begin
						r.send_advert = 1'b1;
						r.advert_priority = me;
						reload_timers();
					end
				end else if (m_mode == MODE_BACKUP && m_down_tmr != '0) begin
					m_down_tmr = m_down_tmr - 1'b1;
					// master gone quiet: take over
					if (m_down_tmr == '0) begin
						m_mode = MODE_MASTER;
						r.add_vmac = 1'b1;
						r.send_advert = 1'b1;
						r.advert_priority = me;
						r.send_garp = 1'b1;
						reload_timers();
					end
				end
			end
			CMD_START: begin
				if (m_mode == MODE_INIT) begin
					if (me == PrioOwner) begin
						m_mode = MODE_MASTER;
						r.add_vmac = 1'b1;
						r.send_advert = 1'b1;
						r.advert_priority = me;
						r.send_garp = 1'b1;
					end else begin
						m_mode = MODE_BACKUP;
					end
					reload_timers();
				end
			end
			CMD_STOP: begin
				if (m_mode != MODE_INIT) begin
					if (m_mode == MODE_MASTER) begin
						r.send_advert = 1'b1;
						r.advert_priority = PrioLeave;
						r.remove_vmac = 1'b1;
					end
					m_mode = MODE_INIT;
					m_adv_tmr = '0;
					m_down_tmr = '0;
				end
			end
			default: begin
				if (m_mode == MODE_INIT)
					r.error_code = ERR_NOT_RUN;
				else if (me == PrioOwner)
					r.error_code = ERR_OWNER_ADV;
				else if (e.adv_auth_type != '0)
					r.error_code = ERR_BAD_AUTH;
				else if (!e.adv_ips_match && e.adv_priority != PrioOwner)
					r.error_code = ERR_BAD_ADDR;
				else if (e.adv_interval != c_intv)
					r.error_code = ERR_BAD_INTV;
				else if (m_mode == MODE_BACKUP) begin
					m_last_adv = e.adv_source;
					if (e.adv_priority == PrioLeave) begin
						m_adv_tmr = '0;
						m_down_tmr = DownTimerW'(TicksPerSec - int'(me));
					end else if (!c_preempt || e.adv_priority >= me) begin
						reload_timers();
					end
				end else begin
					if (e.adv_priority == PrioLeave) begin
						r.send_advert = 1'b1;
						r.advert_priority = me;
						reload_timers();
					end else if (e.adv_priority > me ||
						(e.adv_priority == me && e.adv_source > c_addr)) begin
						// outranked: step down, last advertiser left alone
						m_mode = MODE_BACKUP;
						r.remove_vmac = 1'b1;
						reload_timers();
					end
				end
			end
		endcase
		r.router_state = m_mode;
		r.master_address = (m_mode == MODE_MASTER) ? c_addr : m_last_adv;
	endfunction

	// ---------------------------------------------------------------
	// checking
	// ---------------------------------------------------------------

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	task automatic check_result(input vrrp_out_t got);
		vrrp_out_t want;
		if (router_outputs_due.size() == 0) begin
			$error("result beat with nothing outstanding");
			fails++;
		end else begin
			want = router_outputs_due.pop_front();
			cmp_field("router_state", want.router_state, got.router_state);
			cmp_field("send_advert", want.send_advert, got.send_advert);
			cmp_field("advert_priority", want.advert_priority, got.advert_priority);
			cmp_field("send_garp", want.send_garp, got.send_garp);
			cmp_field("add_vmac", want.add_vmac, got.add_vmac);
			cmp_field("remove_vmac", want.remove_vmac, got.remove_vmac);
			cmp_field("error_code", want.error_code, got.error_code);
			cmp_field("master_address", want.master_address, got.master_address);
		end
	endtask

	// receiver: sample on the edge, stall for a drawn number of cycles after each beat
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && res_ready) begin
				check_result(res);
				hold = stalls_on ? $urandom_range(0, MaxIdle) : 0;
				if (hold != 0)
					res_ready <= 1'b0;
			end else if (hold != 0) begin
				hold = hold - 1;
				if (hold == 0)
					res_ready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------

	function automatic vrrp_in_t beat_of(input cmd_t c, input logic [31:0] src,
		input logic [7:0] pri, input logic [7:0] iv, input logic [7:0] auth, input logic m);
		vrrp_in_t e;
		e.command = c;
		e.adv_source = src;
		e.adv_priority = pri;
		e.adv_interval = iv;
		e.adv_auth_type = auth;
		e.adv_ips_match = m;
		return e;
	endfunction

	// result with no requests raised
	function automatic vrrp_out_t quiet_out(input mode_t st, input err_t er,
		input logic [31:0] addr);
		vrrp_out_t o;
		o = '0;
		o.router_state = st;
		o.error_code = er;
		o.master_address = addr;
		return o;
	endfunction

	task automatic add_write(input logic [2:0] idx, input logic [31:0] data);
		plan_row_t row;
		row = '{default: '0};
		row.is_write = 1'b1;
		row.reg_idx = idx;
		row.reg_data = data;
		plan.push_back(row);
	endtask

	task automatic add_event(input vrrp_in_t e);
		plan_row_t row;
		row = '{default: '0};
		row.ev = e;
		plan.push_back(row);
	endtask

	task automatic add_checked(input vrrp_in_t e, input vrrp_out_t want);
		plan_row_t row;
		row = '{default: '0};
		row.ev = e;
		row.typed = 1'b1;
		row.want = want;
		plan.push_back(row);
	endtask

	// register write, only once every owed result has come back and the pipe has drained
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		evt_valid <= 1'b0;
		while (router_outputs_due.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		apply_reg(idx, data);
		cfg_we <= 1'b0;
	endtask

	// one event beat: optional idle gap, hold valid until taken, then predict
	task automatic send_event(input vrrp_in_t e, input bit typed, input vrrp_out_t want);
		int unsigned gap;
		vrrp_out_t   guess;
		gap = gaps_on ? $urandom_range(0, MaxIdle) : 0;
		if (gap != 0) begin
			evt_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		evt <= e;
		evt_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!evt_ready);
		advance_router(e, guess);
		router_outputs_due.push_back(typed ? want : guess);
	endtask

	// random event steered by the predicted mode; mostly well-formed adverts
	function automatic vrrp_in_t next_random_event();
		vrrp_in_t              e;
		int unsigned           roll;
		logic [DownTimerW-1:0] left;
		e.command = CMD_TICK;
		e.adv_source = $urandom();
		e.adv_priority = 8'($urandom_range(0, 255));
		e.adv_interval = 8'($urandom_range(0, 255));
		e.adv_auth_type = 8'($urandom_range(0, 255));
		e.adv_ips_match = 1'($urandom_range(0, 1));
		if (tick_run != 0) begin
			tick_run--;
			return e;
		end
		roll = $urandom_range(0, 99);
		if (m_mode == MODE_INIT) begin
			if (roll < 60)      e.command = CMD_START;
			else if (roll < 70) e.command = CMD_STOP;
			else if (roll < 80) e.command = CMD_TICK;
			else                e.command = CMD_ADV;
		end else begin
			if (roll < 5)       e.command = CMD_START;
			else if (roll < 10) e.command = CMD_STOP;
			else if (roll < 50) e.command = CMD_TICK;
			else                e.command = CMD_ADV;
		end
		if (e.command == CMD_TICK) begin
			// now and then run the live timer right down to expiry
			left = (m_mode == MODE_MASTER) ? DownTimerW'(m_adv_tmr) : m_down_tmr;
			if (left != '0 && left <= ExpiryReach && $urandom_range(0, 3) == 0)
				tick_run = int'(left) - 1;
			else
				tick_run = $urandom_range(0, 5);
		end else if (e.command == CMD_ADV && $urandom_range(0, 3) != 0) begin
			e.adv_auth_type = '0;
			e.adv_ips_match = 1'b1;
			e.adv_interval = c_intv;
			roll = $urandom_range(0, 99);
			if (roll < 25)
				e.adv_priority = PrioLeave;
			else if (roll < 40) begin
				// owner adverts pass the address check without a match
				e.adv_priority = PrioOwner;
				e.adv_ips_match = 1'($urandom_range(0, 1));
			end else if (roll < 55)
				e.adv_priority = own_priority();
			else
				e.adv_priority = 8'($urandom_range(1, 254));
			case ($urandom_range(0, 5))
				0: e.adv_source = '0;
				1: e.adv_source = '1;
				2: e.adv_source = c_addr;
				default: ;
			endcase
		end
		return e;
	endfunction

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------

	initial begin
		logic [7:0]  prio;
		logic [7:0]  intv;
		logic        pre;
		logic        own;
		logic [31:0] addr;
		int unsigned roll;

		// directed table, starting from reset configuration
		add_checked(beat_of(CMD_TICK, '0, '0, '0, '0, 1'b0),
			quiet_out(MODE_INIT, ERR_OK, '0));
		add_checked(beat_of(CMD_STOP, '1, '1, '1, '1, 1'b1),
			quiet_out(MODE_INIT, ERR_OK, '0));
		add_checked(beat_of(CMD_ADV, 32'h0A00_0001, 8'd100, 8'd1, '0, 1'b1),
			quiet_out(MODE_INIT, ERR_NOT_RUN, '0));
		add_write(REG_LOCAL_ADDRESS, 32'hFFFF_FFFF);
		// writes of the leaving and owner priorities are dropped
		add_write(REG_LOCAL_PRIORITY, {24'h0, PrioLeave});
		add_write(REG_LOCAL_PRIORITY, {24'hFFFFFF, PrioOwner});
		add_write(REG_LOCAL_PRIORITY, 32'd254);
		add_checked(beat_of(CMD_START, '0, '0, '0, '0, 1'b0),
			quiet_out(MODE_BACKUP, ERR_OK, '0));
		// start while running
		add_checked(beat_of(CMD_START, '0, '0, '0, '0, 1'b0),
			quiet_out(MODE_BACKUP, ERR_OK, '0));
		// rejected adverts in check order: bad auth, bad address, then two bad intervals
		add_checked(beat_of(CMD_ADV, 32'h0A00_0001, 8'd100, 8'd1, 8'hFF, 1'b1),
			quiet_out(MODE_BACKUP, ERR_BAD_AUTH, '0));
		add_checked(beat_of(CMD_ADV, 32'h0A00_0001, 8'd100, 8'd1, '0, 1'b0),
			quiet_out(MODE_BACKUP, ERR_BAD_ADDR, '0));
		add_checked(beat_of(CMD_ADV, 32'h0A00_0001, PrioOwner, 8'd255, '0, 1'b0),
			quiet_out(MODE_BACKUP, ERR_BAD_INTV, '0));
		add_checked(beat_of(CMD_ADV, 32'h0A00_0001, 8'd100, 8'd0, '0, 1'b1),
			quiet_out(MODE_BACKUP, ERR_BAD_INTV, '0));
		// lower priority advert with preemption on: no reload
		add_event(beat_of(CMD_ADV, 32'h0A00_0001, 8'd1, 8'd1, '0, 1'b1));
		// leaving master: master-down drops to the skew of two ticks
		add_event(beat_of(CMD_ADV, '0, PrioLeave, 8'd1, '0, 1'b1));
		add_event(beat_of(CMD_TICK, '0, '0, '0, '0, 1'b0));
		add_event(beat_of(CMD_TICK, '0, '0, '0, '0, 1'b0));
		// strictly higher priority takes over
		add_event(beat_of(CMD_ADV, '1, PrioOwner, 8'd1, '0, 1'b0));
		add_event(beat_of(CMD_ADV, 32'hC0A8_0001, PrioLeave, 8'd1, '0, 1'b1));
		add_event(beat_of(CMD_TICK, '0, '0, '0, '0, 1'b0));
		add_event(beat_of(CMD_TICK, '0, '0, '0, '0, 1'b0));
		// master hears a leaving master, then an equal priority from a lower address
		add_event(beat_of(CMD_ADV, 32'h0A00_0002, PrioLeave, 8'd1, '0, 1'b1));
		add_event(beat_of(CMD_ADV, '0, 8'd254, 8'd1, '0, 1'b1));
		// stop while master
		add_event(beat_of(CMD_STOP, '0, '0, '0, '0, 1'b0));
		add_write(REG_ADDRESS_OWNER, 32'd1);
		add_event(beat_of(CMD_START, '0, '0, '0, '0, 1'b0));
		add_checked(beat_of(CMD_ADV, 32'h0A00_0001, 8'd100, 8'd1, '0, 1'b1),
			quiet_out(MODE_MASTER, ERR_OWNER_ADV, 32'hFFFF_FFFF));
		add_event(beat_of(CMD_STOP, '0, '0, '0, '0, 1'b0));

		// reset held first, inputs already at known values
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_write)
				write_reg(plan[i].reg_idx, plan[i].reg_data);
			else
				send_event(plan[i].ev, plan[i].typed, plan[i].want);
		end

		// random phases, each under its own register setting
		for (int unsigned ph = 0; ph < NumPhases; ph++) begin
			case (ph)
				0: begin
					prio = 8'd1; intv = '0; pre = 1'b0; own = 1'b0; addr = '0;
				end
				1: begin
					prio = 8'd254; intv = 8'd255; pre = 1'b1; own = 1'b1; addr = '1;
				end
				default: begin
					if ($urandom_range(0, 7) == 0)
						prio = $urandom_range(0, 1) ? PrioLeave : PrioOwner;
					else
						prio = 8'($urandom_range(1, 254));
					// short intervals mostly, so timers can be run out
					roll = $urandom_range(0, 9);
					if (roll < 6)       intv = 8'd1;
					else if (roll < 8)  intv = '0;
					else if (roll == 8) intv = 8'd2;
					else                intv = 8'($urandom_range(3, 255));
					pre = 1'($urandom_range(0, 1));
					own = ($urandom_range(0, 4) == 0);
					addr = $urandom();
				end
			endcase
			// upper bits of the narrow registers are noise
			write_reg(REG_LOCAL_PRIORITY, {24'($urandom()), prio});
			write_reg(REG_ADVER_INTERVAL, {24'($urandom()), intv});
			write_reg(REG_PREEMPT_ENABLE, {31'($urandom()), pre});
			write_reg(REG_ADDRESS_OWNER, {31'($urandom()), own});
			write_reg(REG_LOCAL_ADDRESS, addr);
			write_reg(REG_SPARE_FIRST + 3'($urandom_range(0, 2)), $urandom());
			// some phases run flat out on one side or both
			gaps_on = ($urandom_range(0, 2) != 0);
			stalls_on = ($urandom_range(0, 2) != 0);
			tick_run = 0;
			for (int unsigned k = 0; k < PhaseBeats; k++)
				send_event(next_random_event(), 1'b0, '0);
			// finish any tick run so it does not leak into the next phase
			while (tick_run != 0)
				send_event(next_random_event(), 1'b0, '0);
		end

		// drain, then settle for stray beats
		evt_valid <= 1'b0;
		while (router_outputs_due.size() != 0)
			@(posedge clk);
		repeat (SettleCycles) @(posedge clk);
		if (fails == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
